/* rtl/swc_pkg.sv */
package swc_pkg;

  // Field widths
  localparam int ASSAY_W   = 24;
  localparam int AMT_W     = 48;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 24;

  localparam int FRAC_BITS_DEF = 24;

  // log2 unit: 32-bit integer in, Q5.32 out
  localparam int LOG_IN_W = 32;
  localparam int LOG_W    = LOG_IN_W + 5;
  localparam int LOG_LAT  = LOG_IN_W + 1;

  // Value function result, unsigned Q.32
  localparam int V_W     = LOG_W + 1;
  localparam int VAL_LAT = LOG_LAT + 4;

  // Work per unit, signed Q.32
  localparam int NUM_W   = V_W + 1 + ASSAY_W + 1;
  localparam int WQ_FRAC = 32;
  localparam int DIVD_W  = AMT_W + WQ_FRAC;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic [ASSAY_W-1:0] FEED_RST  = 24'd119286;
  localparam logic [ASSAY_W-1:0] TAILS_RST = 24'd41943;

  localparam logic [CFG_IDX_W-1:0] REG_FEED  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAILS = 1'd1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ASSAY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

/* rtl/swc_log2.sv */
module swc_log2 import swc_pkg::*; (
  input  logic                clk,
  input  logic [LOG_IN_W-1:0] v,
  output logic [LOG_W-1:0]    log2v
);

  localparam int K_W = LOG_W - LOG_IN_W;

  logic [K_W-1:0]      k_in;
  logic [LOG_IN_W-1:0] m_in;

  logic [LOG_IN_W-1:0] m_q    [0:LOG_IN_W];
  logic [LOG_IN_W-1:0] frac_q [0:LOG_IN_W];
  logic [K_W-1:0]      k_q    [0:LOG_IN_W];

  // Find the leading one and normalize the mantissa to [1,2)
  always_comb begin
    k_in = '0;
    for (int i = 0; i < LOG_IN_W; i++) begin
      if (v[i]) k_in = K_W'(i);
    end
    m_in = v << (K_W'(LOG_IN_W - 1) - k_in);
  end

  always_ff @(posedge clk) begin
    m_q[0]    <= m_in;
    k_q[0]    <= k_in;
    frac_q[0] <= '0;
  end

  // One fraction bit per stage by squaring the mantissa
  for (genvar s = 0; s < LOG_IN_W; s++) begin : g_sq
    logic [2*LOG_IN_W-1:0] sq;
    logic [LOG_IN_W:0]     t;
    assign sq = m_q[s] * m_q[s];
    assign t  = sq[2*LOG_IN_W-1:LOG_IN_W-1];
    always_ff @(posedge clk) begin
      m_q[s+1]    <= t[LOG_IN_W] ? t[LOG_IN_W:1] : t[LOG_IN_W-1:0];
      k_q[s+1]    <= k_q[s];
      frac_q[s+1] <= frac_q[s] | (LOG_IN_W'(t[LOG_IN_W]) << (LOG_IN_W - 1 - s));
    end
  end

  assign log2v = {k_q[LOG_IN_W], frac_q[LOG_IN_W]};

endmodule

/* rtl/swc_value.sv */
module swc_value import swc_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic [ASSAY_W-1:0] a,
  output logic [V_W-1:0]     vout
);

  localparam int D_W   = FRACTION_BITS + 1;
  localparam int X_W   = LOG_IN_W + 2;
  localparam int D_DLY = LOG_LAT + 3;

  logic [X_W-1:0] one, a_x, two_a, diff, dabs;

  logic [LOG_IN_W-1:0] va_q, vb_q;
  logic [D_W-1:0]      d_q [0:D_DLY-1];
  logic [LOG_W-1:0]    la, lb, magl_q, mln_q;
  logic [LOG_W+31:0]   mln_prod;
  logic [LOG_W+D_W-1:0] v_prod;

  assign one   = X_W'(1) << FRACTION_BITS;
  assign a_x   = X_W'(a);
  assign two_a = a_x << 1;
  assign diff  = one - a_x;
  assign dabs  = (two_a >= one) ? (two_a - one) : (one - two_a);

  always_ff @(posedge clk) begin
    va_q   <= {{(LOG_IN_W-ASSAY_W){1'b0}}, a};
    vb_q   <= diff[LOG_IN_W-1:0];
    d_q[0] <= dabs[D_W-1:0];
    for (int i = 1; i < D_DLY; i++) d_q[i] <= d_q[i-1];
  end

  swc_log2 u_log_a (.clk(clk), .v(va_q), .log2v(la));
  swc_log2 u_log_b (.clk(clk), .v(vb_q), .log2v(lb));

  assign mln_prod = magl_q * LN2_Q32;
  assign v_prod   = mln_q * d_q[D_DLY-1];

  // |log2 ratio| -> natural log -> scale by |2x-1|
  always_ff @(posedge clk) begin
    magl_q <= (la >= lb) ? (la - lb) : (lb - la);
    mln_q  <= mln_prod[LOG_W+31:32];
    vout   <= V_W'(v_prod >> FRACTION_BITS);
  end

endmodule

/* rtl/swc_div.sv */
module swc_div import swc_pkg::*; #(
  parameter int N = NUM_W,
  parameter int M = ASSAY_W
) (
  input  logic         clk,
  input  logic [N-1:0] dividend,
  input  logic [M-1:0] divisor,
  output logic [N-1:0] quotient
);

  logic [M-1:0] rem_q [0:N-1];
  logic [N-1:0] num_q [0:N-1];
  logic [M-1:0] div_q [0:N-1];

  // Restoring division, one quotient bit per stage
  for (genvar s = 0; s < N; s++) begin : g_st
    logic [M-1:0] rem_in, div_in;
    logic [N-1:0] num_in;
    logic [M:0]   r2;
    logic         ge;
    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = dividend;
      assign div_in = divisor;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign num_in = num_q[s-1];
      assign div_in = div_q[s-1];
    end
    assign r2 = {rem_in, num_in[N-1]};
    assign ge = r2 >= {1'b0, div_in};
    always_ff @(posedge clk) begin
      rem_q[s] <= ge ? M'(r2 - {1'b0, div_in}) : r2[M-1:0];
      num_q[s] <= {num_in[N-2:0], ge};
      div_q[s] <= div_in;
    end
  end

  assign quotient = num_q[N-1];

endmodule

/* rtl/separative_work_converter.sv */
// Separative work converter. Each item gives the work per kilogram of product
// W = V(xp) + V(xw)(xp-xf)/(xf-xw) - V(xf)(xp-xw)/(xf-xw), V(x)=(2x-1)ln(x/(1-x)),
// and with func 0 divides amount_in (work) by W to give mass, with func 1
// multiplies amount_in (mass) by W to give work, all in fixed point. The block
// is one deep pipeline: busy stays low, an item may be started on every clock,
// and its result appears on amount_out/status with done high for one cycle.
// The depth of the pipeline is set by the log2 units (one squaring per
// fraction bit), the 64-stage divider for W and the 80-stage divider for
// the mass quotient. There is no back-pressure: the receiver must
// take each result in the cycle it is shown. An invalid assay (zero, not below
// one, or feed equal to tails) returns status 1 and zero; W not positive
// returns status 2 and zero; a result beyond 48 bits saturates with status 2.
// Write feed_assay and tails_assay only while no item is in flight.
module separative_work_converter import swc_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output logic                 done,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 func,
  input  logic [ASSAY_W-1:0]   product_assay,
  input  logic [AMT_W-1:0]     amount_in,
  output logic [AMT_W-1:0]     amount_out,
  output logic [STATUS_W-1:0]  status
);

  localparam int Q_LAT    = NUM_W;
  localparam int MUL_LAT  = 3;
  localparam int MD_LAT   = DIVD_W - MUL_LAT;
  localparam int PIPE_LAT = VAL_LAT + 3 + Q_LAT + 3 + DIVD_W + 2;

  // Product split for the final multiply
  localparam int MH   = AMT_W / 2;
  localparam int WH   = NUM_W / 2;
  localparam int PP_W = MH + WH;
  localparam int S_W  = PP_W + MH + 1;
  localparam int P_W  = S_W + WH;

  typedef struct packed {
    logic               valid;
    logic               func;
    logic               bad;
    logic [ASSAY_W-1:0] p;
    logic [AMT_W-1:0]   amt;
  } sb_t;

  logic [ASSAY_W-1:0] feed_assay, tails_assay;
  logic               accept, in_bad;

  sb_t sb0, sb2, sb3, sb4, sb6, sb7, sb8;
  sb_t sba [0:VAL_LAT-1];
  sb_t sbb [0:Q_LAT-1];
  sb_t sbc [0:DIVD_W-1];

  logic [V_W-1:0] vp1, vf1, vw1, vp2, vp3, vp4, vp6;
  logic [V_W-1:0] vpb [0:Q_LAT-1];
  logic           qnegb [0:Q_LAT-1];
  logic           nonposc [0:DIVD_W-1];

  logic signed [ASSAY_W:0]  pf, pw, den2, den3;
  logic signed [NUM_W-1:0]  t1, t2, num3;
  logic [NUM_W-1:0]         nmag4, qmag5, qs6, wq7;
  logic [ASSAY_W-1:0]       dmag4;
  logic                     qneg4;

  logic [DIVD_W-1:0] dividend8, q9;
  logic [NUM_W-1:0]  divisor8;
  logic              nonpos8;

  logic [PP_W-1:0]  pll, phl, plh, phh;
  logic [S_W-1:0]   s1, s2;
  logic [P_W-1:0]   prod;
  logic [AMT_W-1:0] mres;
  logic             msat;
  logic [AMT_W-1:0] mres_d [0:MD_LAT-1];
  logic             msat_d [0:MD_LAT-1];

  function automatic logic assay_ok(input logic [ASSAY_W-1:0] x);
    return (x != '0) && ((33'(x) >> FRACTION_BITS) == '0);
  endfunction

  // Every cycle can take an item
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign in_bad = !assay_ok(product_assay) || !assay_ok(feed_assay) ||
                  !assay_ok(tails_assay) || (feed_assay == tails_assay);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      feed_assay  <= FEED_RST;
      tails_assay <= TAILS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_FEED:  feed_assay  <= cfg_wdata[ASSAY_W-1:0];
        REG_TAILS: tails_assay <= cfg_wdata[ASSAY_W-1:0];
        default:   ;
      endcase
    end
  end

  // Capture the item; the assay check is settled here
  always_ff @(posedge clk) begin
    if (rst) begin
      sb0.valid <= 1'b0;
    end else begin
      sb0.valid <= accept;
      sb0.func  <= func;
      sb0.bad   <= in_bad;
      sb0.p     <= product_assay;
      sb0.amt   <= amount_in;
    end
  end

  // Value function for product, feed and tails in parallel lanes
  swc_value #(.FRACTION_BITS(FRACTION_BITS)) u_vp (.clk(clk), .a(sb0.p),       .vout(vp1));
  swc_value #(.FRACTION_BITS(FRACTION_BITS)) u_vf (.clk(clk), .a(feed_assay),  .vout(vf1));
  swc_value #(.FRACTION_BITS(FRACTION_BITS)) u_vw (.clk(clk), .a(tails_assay), .vout(vw1));

  // Control travels alongside the data; hold valid bits clear in reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VAL_LAT; i++) sba[i].valid <= 1'b0;
      for (int i = 0; i < Q_LAT; i++) sbb[i].valid <= 1'b0;
      for (int i = 0; i < DIVD_W; i++) sbc[i].valid <= 1'b0;
      sb2.valid <= 1'b0;
      sb3.valid <= 1'b0;
      sb4.valid <= 1'b0;
      sb6.valid <= 1'b0;
      sb7.valid <= 1'b0;
      sb8.valid <= 1'b0;
    end else begin
      sba[0] <= sb0;
      for (int i = 1; i < VAL_LAT; i++) sba[i] <= sba[i-1];
      sb2 <= sba[VAL_LAT-1];
      sb3 <= sb2;
      sb4 <= sb3;
      sbb[0] <= sb4;
      for (int i = 1; i < Q_LAT; i++) sbb[i] <= sbb[i-1];
      sb6 <= sbb[Q_LAT-1];
      sb7 <= sb6;
      sb8 <= sb7;
      sbc[0] <= sb8;
      for (int i = 1; i < DIVD_W; i++) sbc[i] <= sbc[i-1];
    end
  end

  // Numerator terms of the cascade balance
  assign pf = $signed({1'b0, sba[VAL_LAT-1].p}) - $signed({1'b0, feed_assay});
  assign pw = $signed({1'b0, sba[VAL_LAT-1].p}) - $signed({1'b0, tails_assay});

  always_ff @(posedge clk) begin
    t1   <= $signed({1'b0, vw1}) * pf;
    t2   <= $signed({1'b0, vf1}) * pw;
    den2 <= $signed({1'b0, feed_assay}) - $signed({1'b0, tails_assay});
    vp2  <= vp1;

    num3 <= t1 - t2;
    den3 <= den2;
    vp3  <= vp2;

    // Divide magnitudes; the quotient sign is restored afterward
    nmag4 <= num3[NUM_W-1] ? NUM_W'(-num3) : NUM_W'(num3);
    dmag4 <= den3[ASSAY_W] ? ASSAY_W'(-den3) : ASSAY_W'(den3);
    qneg4 <= num3[NUM_W-1] ^ den3[ASSAY_W];
    vp4   <= vp3;
  end

  swc_div #(.N(NUM_W), .M(ASSAY_W)) u_div_w (
    .clk(clk), .dividend(nmag4), .divisor(dmag4), .quotient(qmag5)
  );

  always_ff @(posedge clk) begin
    vpb[0]   <= vp4;
    qnegb[0] <= qneg4;
    for (int i = 1; i < Q_LAT; i++) begin
      vpb[i]   <= vpb[i-1];
      qnegb[i] <= qnegb[i-1];
    end
    // Keep V(xp) in step with the signed quotient
    qs6 <= qnegb[Q_LAT-1] ? (~qmag5 + 1'b1) : qmag5;
    vp6 <= vpb[Q_LAT-1];
    wq7 <= NUM_W'(vp6) + qs6;

    nonpos8   <= wq7[NUM_W-1] || (wq7 == '0);
    divisor8  <= wq7;
    dividend8 <= {sb7.amt, {WQ_FRAC{1'b0}}};

    // Mass to work: four partial products, then two add levels
    pll <= sb7.amt[MH-1:0]     * wq7[WH-1:0];
    phl <= sb7.amt[AMT_W-1:MH] * wq7[WH-1:0];
    plh <= sb7.amt[MH-1:0]     * wq7[NUM_W-1:WH];
    phh <= sb7.amt[AMT_W-1:MH] * wq7[NUM_W-1:WH];
    s1   <= S_W'(pll) + (S_W'(phl) << MH);
    s2   <= S_W'(plh) + (S_W'(phh) << MH);
    prod <= P_W'(s1) + (P_W'(s2) << WH);
    mres <= prod[DIVD_W-1:WQ_FRAC];
    msat <= prod[P_W-1:DIVD_W] != '0;

    mres_d[0] <= mres;
    msat_d[0] <= msat;
    for (int i = 1; i < MD_LAT; i++) begin
      mres_d[i] <= mres_d[i-1];
      msat_d[i] <= msat_d[i-1];
    end
    nonposc[0] <= nonpos8;
    for (int i = 1; i < DIVD_W; i++) nonposc[i] <= nonposc[i-1];
  end

  // Work to mass: 80-bit quotient, anything above bit 47 saturates
  swc_div #(.N(DIVD_W), .M(NUM_W)) u_div_m (
    .clk(clk), .dividend(dividend8), .divisor(divisor8), .quotient(q9)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sbc[DIVD_W-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    priority if (sbc[DIVD_W-1].bad) begin
      amount_out <= '0;
      status     <= ST_ASSAY;
    end else if (nonposc[DIVD_W-1]) begin
      amount_out <= '0;
      status     <= ST_RANGE;
    end else if (!sbc[DIVD_W-1].func) begin
      if (q9[DIVD_W-1:AMT_W] != '0) begin
        amount_out <= '1;
        status     <= ST_RANGE;
      end else begin
        amount_out <= q9[AMT_W-1:0];
        status     <= ST_OK;
      end
    end else begin
      amount_out <= msat_d[MD_LAT-1] ? '1 : mres_d[MD_LAT-1];
      status     <= msat_d[MD_LAT-1] ? ST_RANGE : ST_OK;
    end
  end

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##PIPE_LAT done)
    else $error("accepted item gave no result at the pipeline latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, PIPE_LAT))
    else $error("result without a matching accepted item");

  a_assay_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_ASSAY) |-> amount_out == '0)
    else $error("invalid assay result is not zero");

  a_range_value: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_RANGE && amount_out != '0) |-> (&amount_out))
    else $error("range status with a value that is neither zero nor saturated");

endmodule

/* tb/sv/separative_work_converter_tb.sv */
module separative_work_converter_tb;
  import swc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT  = 188;
  localparam int IDLE_WAIT = PIPE_LAT + 20;
  localparam int WDOG_MAX  = 4000;
  localparam logic [63:0] ONE_Q24 = 64'd1 << 24;
  localparam logic [63:0] AMT_MAX = (64'd1 << AMT_W) - 1;

  typedef struct packed {
    logic               func;
    logic [ASSAY_W-1:0] product_assay;
    logic [AMT_W-1:0]   amount_in;
  } conv_item_t;

  typedef struct packed {
    logic [AMT_W-1:0]    amount_out;
    logic [STATUS_W-1:0] status;
  } conv_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = REG_FEED;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic func = 1'b0;
  logic [ASSAY_W-1:0] product_assay = '0;
  logic [AMT_W-1:0] amount_in = '0;
  logic [AMT_W-1:0] amount_out;
  logic [STATUS_W-1:0] status;

  separative_work_converter uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .func(func), .product_assay(product_assay), .amount_in(amount_in),
    .amount_out(amount_out), .status(status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow copy of the assay registers, updated as each write goes in.
  logic [63:0] feed_q = 64'(FEED_RST);
  logic [63:0] tails_q = 64'(TAILS_RST);

  conv_item_t   pending_items[$];
  conv_result_t expected_results[$];
  bit failed = 1'b0;

  // log2 of v in [1, 2^32), Q.32, by repeated squaring with truncation.
  function automatic logic [63:0] log2_q32(logic [63:0] v);
    int k;
    logic [63:0] m, frac;
    k = 0;
    frac = '0;
    while (k < 31 && (v >> (k + 1)) != 0) k++;
    m = v << (31 - k);
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        frac[31-i] = 1'b1;
      end
    end
    return (64'(k) << 32) | frac;
  endfunction

  // V(a/2^24) = |2a-1| * |ln(a/(1-a))|, unsigned Q.32.
  function automatic logic [63:0] value_q32(logic [63:0] a);
    logic [63:0] la, lb, magl, d;
    logic [127:0] p;
    la = log2_q32(a);
    lb = log2_q32(ONE_Q24 - a);
    magl = (la >= lb) ? la - lb : lb - la;
    d = (2 * a >= ONE_Q24) ? 2 * a - ONE_Q24 : ONE_Q24 - 2 * a;
    p = 128'(magl) * 128'(LN2_Q32);
    p = 128'(p[95:32]) * 128'(d);
    return p[87:24];
  endfunction

  function automatic bit assay_valid(logic [63:0] a);
    return a != 0 && a < ONE_Q24;
  endfunction

  function automatic conv_result_t convert(conv_item_t it);
    conv_result_t r;
    logic signed [63:0] vp, vw, vf, num, den, wq, ps, fs, ws;
    logic [79:0] dividend, quo;
    logic [127:0] prod;
    r.amount_out = '0;
    r.status = ST_OK;
    if (!assay_valid(64'(it.product_assay)) || !assay_valid(feed_q) ||
        !assay_valid(tails_q) || feed_q == tails_q) begin
      r.status = ST_ASSAY;
      return r;
    end
    ps = $signed(64'(it.product_assay));
    fs = $signed(feed_q);
    ws = $signed(tails_q);
    vp = $signed(value_q32(64'(it.product_assay)));
    vw = $signed(value_q32(tails_q));
    vf = $signed(value_q32(feed_q));
    num = vw * (ps - fs) - vf * (ps - ws);
    den = fs - ws;
    wq = vp + num / den;
    if (wq <= 0) begin
      r.status = ST_RANGE;
      return r;
    end
    if (!it.func) begin
      dividend = {it.amount_in, 32'd0};
      quo = dividend / 80'(wq);
      if (quo[79:48] != 0) begin
        r.amount_out = AMT_MAX[AMT_W-1:0];
        r.status = ST_RANGE;
      end else begin
        r.amount_out = quo[47:0];
      end
    end else begin
      prod = 128'(it.amount_in) * 128'(wq);
      if (prod[127:96] != 0 || prod[95:80] != 0) begin
        r.amount_out = AMT_MAX[AMT_W-1:0];
        r.status = ST_RANGE;
      end else begin
        r.amount_out = prod[79:32];
      end
    end
    return r;
  endfunction

  // Driver: bursts of items with random gaps; hold an item until it is taken.
  bit taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      // hold the current item
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_items.size() == 0) begin
      start <= 1'b0;
    end else begin
      conv_item_t it;
      it = pending_items.pop_front();
      start <= 1'b1;
      func <= it.func;
      product_assay <= it.product_assay;
      amount_in <= it.amount_in;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        // long stretches with no gap now and then
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Monitor: predict on accept, check on done, watch for a stall.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst) begin
      conv_item_t it;
      conv_result_t exp_r;
      it.func = func;
      it.product_assay = product_assay;
      it.amount_in = amount_in;
      taken <= start && !busy;
      if (start && !busy) expected_results.push_back(convert(it));
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: amount_out %h status %0d",
                 amount_out, status);
          failed = 1'b1;
        end else begin
          exp_r = expected_results.pop_front();
          if (amount_out !== exp_r.amount_out) begin
            $error("amount_out: expected %h, got %h", exp_r.amount_out, amount_out);
            failed = 1'b1;
          end
          if (status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status);
            failed = 1'b1;
          end
        end
      end
      if ((start && !busy) || done) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Write one register at a falling edge; keep the shadow copy in step.
  task automatic write_assay(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    if (idx == REG_FEED) feed_q = 64'(val);
    else tails_q = 64'(val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic add_item(logic f, logic [ASSAY_W-1:0] pa, logic [AMT_W-1:0] amt);
    conv_item_t it;
    it.func = f;
    it.product_assay = pa;
    it.amount_in = amt;
    pending_items.push_back(it);
  endtask

  // Amounts over many magnitudes so both tiny and saturating values occur.
  function automatic logic [AMT_W-1:0] rand_amount();
    logic [AMT_W-1:0] a;
    a = AMT_W'({$urandom(), $urandom()});
    return a >> $urandom_range(0, 47);
  endfunction

  // Mostly valid assays; zero and the top value now and then.
  function automatic logic [ASSAY_W-1:0] rand_assay();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      2: return ASSAY_W'(feed_q);
      3: return ASSAY_W'(tails_q);
      4: return ASSAY_W'($urandom_range(1, 300000));
      default: return ASSAY_W'($urandom_range(1, (1 << ASSAY_W) - 1));
    endcase
  endfunction

  task automatic random_items(int n);
    repeat (n) add_item(1'($urandom_range(0, 1)), rand_assay(), rand_amount());
  endtask

  // Drain: all items taken, all results back, pipeline empty.
  task automatic drain();
    wait (pending_items.size() == 0 && !start && expected_results.size() == 0);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, both directions, special cases.
    add_item(1'b0, 24'd0, 48'd1000);
    add_item(1'b1, 24'hFFFFFF, 48'd1000);
    add_item(1'b0, 24'd1, '1);
    add_item(1'b1, 24'd1, '1);
    add_item(1'b0, 24'd1677722, 48'd0);
    add_item(1'b1, 24'd1677722, 48'd0);
    add_item(1'b0, 24'd838861, 48'h0000_0001_0000);
    add_item(1'b1, 24'd838861, 48'h0000_0001_0000);
    add_item(1'b1, 24'hFFFFFE, '1);
    add_item(1'b0, 24'hFFFFFE, 48'd1);
    add_item(1'b0, FEED_RST, 48'h0010_0000_0000);
    add_item(1'b1, FEED_RST, 48'h0010_0000_0000);
    add_item(1'b0, TAILS_RST, 48'h0000_0100_0000);
    add_item(1'b1, 24'd60000, 48'h5555_5555_5555);
    add_item(1'b0, 24'd60000, 48'hAAAA_AAAA_AAAA);
    add_item(1'b1, 24'h800000, 48'hFFFF_0000_FFFF);
    random_items(180);
    drain();

    // Product richer than feed is normal; tails above feed makes W negative.
    write_assay(REG_FEED, 24'd1);
    write_assay(REG_TAILS, 24'hFFFFFF);
    add_item(1'b0, 24'd1, 48'd5000);
    add_item(1'b1, 24'h800000, 48'd5000);
    random_items(100);
    drain();

    // Equal feed and tails.
    write_assay(REG_TAILS, 24'd1);
    random_items(40);
    drain();

    // Zero feed.
    write_assay(REG_FEED, 24'd0);
    write_assay(REG_TAILS, 24'd41943);
    random_items(40);
    drain();

    // Random valid settings.
    repeat (3) begin
      write_assay(REG_TAILS, ASSAY_W'($urandom_range(1, 200000)));
      write_assay(REG_FEED, ASSAY_W'($urandom_range(1, (1 << ASSAY_W) - 1)));
      random_items(110);
      drain();
    end

    if (!failed && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
